### hw/rtl/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared constants and types for the 2-D median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

    localparam int DEF_MAX_RADIUS = 3;
    localparam int DEF_MAX_WIDTH  = 1024;

    localparam int PIX_W = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // Hand-off between neighbouring sort cells
    typedef struct packed {
        logic [PIX_W-1:0] val;
        logic             valid;
        logic             take;
    } mf2d_link_t;

endpackage

### hw/rtl/median_filter_2d_core.sv
// ----------------------------------------------------------------------------
// median_filter_2d_core
// Streaming square-window median filter for 8-bit grayscale images.
// ----------------------------------------------------------------------------
// Input stream: tdata = pixel_in, tuser = flush. Output stream: tdata =
// pixel_out, tlast = frame_last. Pixels arrive in raster order; the output
// lags by r rows plus r pixels, so after the last pixel the source sends
// flush items until tlast is seen. Border pixels pass through unchanged.
// Each item is handled on its own. For an interior pixel the window is
// read from the line store one pixel a cycle (single read port) and
// inserted into the sort chain; a border pixel reads back only itself.
// The result sits in an output register; the next item is accepted while
// it waits, and the block stalls only when a second result is due before
// the first is taken.
// Reset clears positions and sets width 1024, height 1024, radius 1; there
// is no clearing pass. A configuration write restarts the frame.
// ----------------------------------------------------------------------------
module median_filter_2d_core #(
    parameter int MAX_RADIUS = mf2d_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = mf2d_pkg::DEF_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
    input  logic        s_axis_tuser,   // [0] flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import mf2d_pkg::*;

    localparam int SLOTS  = 2 * MAX_RADIUS + 1;
    localparam int NCELLS = SLOTS * SLOTS;
    localparam int SW     = $clog2(SLOTS);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int LAGW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int MW     = $clog2(NCELLS);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DRAIN, ST_EMIT} state_t;

    state_t          state_reg;
    logic [10:0]     width_reg;
    logic [15:0]     height_reg;
    logic [1:0]      radius_reg;
    logic [CW-1:0]   in_col_reg;
    logic [15:0]     in_row_reg;
    logic [SW-1:0]   in_slot_reg;
    logic [CW-1:0]   out_col_reg;
    logic [15:0]     out_row_reg;
    logic [SW-1:0]   out_slot_reg;
    logic [LAGW-1:0] seen_reg;
    logic [SW-1:0]   win_r_reg;
    logic [SW-1:0]   win_c_reg;
    logic            border_reg;
    logic            rd_pend_reg;
    logic            m_valid_reg;
    logic [7:0]      m_data_reg;
    logic            m_last_reg;

    logic [WW-1:0]   w_eff;
    logic [15:0]     h_eff;
    logic [RW-1:0]   r_eff;
    logic [LAGW-1:0] lag;
    logic [SW-1:0]   side;
    logic [MW-1:0]   med_idx;
    logic            accept;
    logic            done;
    logic            ignored;
    logic            due;
    logic            interior;
    logic            last;
    logic [SW:0]     base_ext;
    logic [SW:0]     rs_ext;
    logic [SW-1:0]   rd_slot;
    logic [CW-1:0]   rd_col;
    logic [7:0]      rd_q;
    logic [7:0]      median;

    always_comb
    begin
        if (width_reg == 11'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
    end

    assign lag     = LAGW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
    assign side    = SW'(2 * 32'(r_eff));
    assign med_idx = MW'(2 * 32'(r_eff) * (32'(r_eff) + 1));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign done    = in_row_reg >= h_eff;
    assign ignored = s_axis_tuser && !done;
    assign due     = seen_reg >= lag;

    assign interior = (32'(out_row_reg) >= 32'(r_eff))
                   && (32'(out_row_reg) + 32'(r_eff) < 32'(h_eff))
                   && (32'(out_col_reg) >= 32'(r_eff))
                   && (32'(out_col_reg) + 32'(r_eff) < 32'(w_eff));
    assign last = (out_row_reg == h_eff - 16'd1)
               && (32'(out_col_reg) == 32'(w_eff) - 1);

    // window row slot, wrapped modulo the slot count
    always_comb
    begin
        if (32'(out_slot_reg) >= 32'(r_eff))
        begin
            base_ext = (SW+1)'(32'(out_slot_reg) - 32'(r_eff));
        end
        else
        begin
            base_ext = (SW+1)'(32'(out_slot_reg) + SLOTS - 32'(r_eff));
        end
        rs_ext = base_ext + (SW+1)'(win_r_reg);
        if (32'(rs_ext) >= SLOTS)
        begin
            rs_ext = (SW+1)'(32'(rs_ext) - SLOTS);
        end
        if (border_reg)
        begin
            rd_slot = out_slot_reg;
            rd_col  = out_col_reg;
        end
        else
        begin
            rd_slot = SW'(rs_ext);
            rd_col  = CW'(32'(out_col_reg) - 32'(r_eff) + 32'(win_c_reg));
        end
    end

    mf2d_line_store #(
        .SLOTS     (SLOTS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && !done && !s_axis_tuser),
        .wslot (in_slot_reg),
        .wcol  (in_col_reg),
        .wdata (s_axis_tdata),
        .re    (state_reg == ST_READ),
        .rslot (rd_slot),
        .rcol  (rd_col),
        .q     (rd_q)
    );

    mf2d_sort_chain #(
        .NCELLS (NCELLS)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (accept),
        .ins     (rd_pend_reg && !border_reg),
        .din     (rd_q),
        .med_idx (med_idx),
        .median  (median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            width_reg    <= 11'd1024;
            height_reg   <= 16'd1024;
            radius_reg   <= 2'd1;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            seen_reg     <= '0;
            win_r_reg    <= '0;
            win_c_reg    <= '0;
            border_reg   <= 1'b0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == ST_READ);
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_WIDTH:  width_reg  <= cfg_wdata[10:0];
                    REG_HEIGHT: height_reg <= cfg_wdata;
                    REG_RADIUS: radius_reg <= cfg_wdata[1:0];
                    default:    ;
                endcase
                if (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT
                    || cfg_addr == REG_RADIUS)
                begin
                    in_col_reg   <= '0;
                    in_row_reg   <= '0;
                    in_slot_reg  <= '0;
                    out_col_reg  <= '0;
                    out_row_reg  <= '0;
                    out_slot_reg <= '0;
                    seen_reg     <= '0;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !ignored)
                    begin
                        if (!due)
                        begin
                            seen_reg <= seen_reg + LAGW'(1);
                        end
                        if (!done)
                        begin
                            if (32'(in_col_reg) + 1 >= 32'(w_eff))
                            begin
                                in_col_reg <= '0;
                                in_row_reg <= in_row_reg + 16'd1;
                                in_slot_reg <= (32'(in_slot_reg) == SLOTS - 1)
                                             ? '0 : in_slot_reg + SW'(1);
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + CW'(1);
                            end
                        end
                        if (due)
                        begin
                            border_reg <= !interior;
                            win_r_reg  <= '0;
                            win_c_reg  <= '0;
                            state_reg  <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    if (border_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else if (win_c_reg == side)
                    begin
                        win_c_reg <= '0;
                        if (win_r_reg == side)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            win_r_reg <= win_r_reg + SW'(1);
                        end
                    end
                    else
                    begin
                        win_c_reg <= win_c_reg + SW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= border_reg ? rd_q : median;
                        m_last_reg  <= last;
                        state_reg   <= ST_IDLE;
                        if (last)
                        begin
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                            seen_reg     <= '0;
                        end
                        else if (32'(out_col_reg) + 1 >= 32'(w_eff))
                        begin
                            out_col_reg  <= '0;
                            out_row_reg  <= out_row_reg + 16'd1;
                            out_slot_reg <= (32'(out_slot_reg) == SLOTS - 1)
                                          ? '0 : out_slot_reg + SW'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

### hw/rtl/mf2d_sort_cell.sv
// ----------------------------------------------------------------------------
// mf2d_sort_cell
// One cell of the insertion sort chain; holds one window pixel.
// ----------------------------------------------------------------------------
module mf2d_sort_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 ins,
    input  logic [7:0]           din,
    input  mf2d_pkg::mf2d_link_t prev,
    output mf2d_pkg::mf2d_link_t link
);
    import mf2d_pkg::*;

    logic [PIX_W-1:0] val_reg;
    logic [PIX_W-1:0] val_next;
    logic             valid_reg;
    logic             valid_next;
    logic             take;

    // an empty cell counts as +inf
    assign take = ins && (!valid_reg || (din < val_reg));

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            if (take)
            begin
                val_next = prev.take ? prev.val : din;
            end
            if (ins && prev.valid)
            begin
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign link.val   = val_reg;
    assign link.valid = valid_reg;
    assign link.take  = take;

endmodule

### hw/rtl/mf2d_sort_chain.sv
// ----------------------------------------------------------------------------
// mf2d_sort_chain
// Row of sort cells; one pixel inserted per cycle, median tapped by index.
// ----------------------------------------------------------------------------
module mf2d_sort_chain #(
    parameter int NCELLS = 49
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      ins,
    input  logic [7:0]                din,
    input  logic [$clog2(NCELLS)-1:0] med_idx,
    output logic [7:0]                median
);
    import mf2d_pkg::*;

    mf2d_link_t links [NCELLS+1];
    logic [PIX_W-1:0] vals [NCELLS];

    // head of the chain: always valid, never shifts in
    assign links[0].val   = '0;
    assign links[0].valid = 1'b1;
    assign links[0].take  = 1'b0;

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        mf2d_sort_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .clear (clear),
            .ins   (ins),
            .din   (din),
            .prev  (links[i]),
            .link  (links[i+1])
        );
        assign vals[i] = links[i+1].val;
    end

    assign median = vals[med_idx];

endmodule

### hw/rtl/mf2d_line_store.sv
// ----------------------------------------------------------------------------
// mf2d_line_store
// Row buffer memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mf2d_line_store #(
    parameter int SLOTS     = 7,
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(SLOTS)-1:0]     wslot,
    input  logic [$clog2(MAX_WIDTH)-1:0] wcol,
    input  logic [7:0]                   wdata,
    input  logic                         re,
    input  logic [$clog2(SLOTS)-1:0]     rslot,
    input  logic [$clog2(MAX_WIDTH)-1:0] rcol,
    output logic [7:0]                   q
);
    import mf2d_pkg::*;

    logic [PIX_W-1:0] mem [SLOTS][MAX_WIDTH];
    logic [PIX_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wslot][wcol] <= wdata;
        end
        if (re)
        begin
            q_reg <= mem[rslot][rcol];
        end
    end

    assign q = q_reg;

endmodule
